>>> rtl/ifsf_pkg.sv
`default_nettype none
package ifsf_pkg;

   localparam int unsigned BYTE_W = 8;

   // Output slots of one input beat, in the order they leave the block.
   localparam int unsigned SLOT_COUNT     = 9;
   localparam int unsigned SLOT_OPEN_FLAG = 0;
   localparam int unsigned SLOT_ADDRESS   = 1;
   localparam int unsigned SLOT_CONTROL   = 2;
   localparam int unsigned SLOT_BCC1      = 3;
   localparam int unsigned SLOT_DATA_ESC  = 4;
   localparam int unsigned SLOT_DATA      = 5;
   localparam int unsigned SLOT_BCC2_ESC  = 6;
   localparam int unsigned SLOT_BCC2      = 7;
   localparam int unsigned SLOT_CLOSE     = 8;

   localparam logic [BYTE_W-1:0] STUFF_XOR = 8'h20;

   // Register indexes of the configuration port.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLAG     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEQ_MASK = 2'd3;

   localparam logic [BYTE_W-1:0] FLAG_RESET     = 8'h7E;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET   = 8'h7D;
   localparam logic [BYTE_W-1:0] ADDRESS_RESET  = 8'h03;
   localparam logic [BYTE_W-1:0] SEQ_MASK_RESET = 8'h40;

   typedef logic [SLOT_COUNT-1:0] slot_type;

   typedef struct packed {
      logic [BYTE_W-1:0] flag;
      logic [BYTE_W-1:0] escape;
      logic [BYTE_W-1:0] address;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              data_stuff;
      logic [BYTE_W-1:0] check;
      logic              check_stuff;
      logic [BYTE_W-1:0] control;
   } item_type;

endpackage
`default_nettype wire

>>> rtl/ifsf_slot_mux.sv
`default_nettype none
module ifsf_slot_mux (
   input  wire ifsf_pkg::slot_type                 slot,
   input  wire ifsf_pkg::item_type                 item,
   input  wire ifsf_pkg::cfg_type                  cfg,
   output logic [ifsf_pkg::BYTE_W-1:0]             frame_byte,
   output logic                                    frame_end
);

   always_comb begin
      frame_byte = '0;
      frame_end  = 1'b0;
      unique case (1'b1)
         slot[ifsf_pkg::SLOT_OPEN_FLAG]: frame_byte = cfg.flag;
         slot[ifsf_pkg::SLOT_ADDRESS]:   frame_byte = cfg.address;
         slot[ifsf_pkg::SLOT_CONTROL]:   frame_byte = item.control;
         slot[ifsf_pkg::SLOT_BCC1]:      frame_byte = cfg.address ^ item.control;
         slot[ifsf_pkg::SLOT_DATA_ESC]:  frame_byte = cfg.escape;
         slot[ifsf_pkg::SLOT_DATA]: begin
            frame_byte = item.data_stuff ? (item.data ^ ifsf_pkg::STUFF_XOR) : item.data;
         end
         slot[ifsf_pkg::SLOT_BCC2_ESC]:  frame_byte = cfg.escape;
         slot[ifsf_pkg::SLOT_BCC2]: begin
            frame_byte = item.check_stuff ? (item.check ^ ifsf_pkg::STUFF_XOR) : item.check;
         end
         slot[ifsf_pkg::SLOT_CLOSE]: begin
            frame_byte = cfg.flag;
            frame_end  = 1'b1;
         end
         default: begin
            frame_byte = '0;
            frame_end  = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/info_frame_stuffing_framer.sv
// Information-frame builder with byte stuffing.
// req_ channel: one packet byte per beat (req_data_byte), req_last_byte on the
// final byte, req_sequence_bit sampled on the first byte of each frame.
// rsp_ channel: the frame, one byte per beat. rsp_run_last marks the last beat
// caused by an input beat, rsp_frame_end marks the closing flag.
// csr_ channel: write-only registers flag, escape, address and sequence mask,
// always ready; write them only while the block is idle.
// Flow: an accepted beat is held with its slots, then its first output byte
// moves into the output register. Each input beat yields 1 to 9 output beats,
// one per cycle while rsp_ready is high or the output register is empty: the
// header (flag, address, control, BCC1) on opening, the data byte with its
// escape when stuffed, then BCC2, escaped when stuffed, and the closing flag
// on the last byte; the next beat is taken as the held beat's last slot leaves.
// Reset: clears the frame state (next byte opens a frame with check 0),
// restores register defaults and empties the output register.
// Stall: while rsp_ready is low the output register holds its beat, the slot
// walker holds, and req_ready drops once the current beat has slots left.
`default_nettype none
module info_frame_stuffing_framer (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [ifsf_pkg::BYTE_W-1:0]          req_data_byte,
   input  wire                                  req_last_byte,
   input  wire                                  req_sequence_bit,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [ifsf_pkg::BYTE_W-1:0]          rsp_frame_byte,
   output logic                                 rsp_run_last,
   output logic                                 rsp_frame_end,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [ifsf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [ifsf_pkg::BYTE_W-1:0]          csr_data
);

   // Configuration registers.
   logic [ifsf_pkg::BYTE_W-1:0] flag_ff, flag_in;
   logic [ifsf_pkg::BYTE_W-1:0] escape_ff, escape_in;
   logic [ifsf_pkg::BYTE_W-1:0] address_ff, address_in;
   logic [ifsf_pkg::BYTE_W-1:0] seq_mask_ff, seq_mask_in;

   // Frame state.
   logic [ifsf_pkg::BYTE_W-1:0] check_ff, check_in;
   logic                        inside_ff, inside_in;

   // Held input beat and its outstanding slots.
   ifsf_pkg::item_type          item_ff, item_in;
   ifsf_pkg::slot_type          pending_ff, pending_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ifsf_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_end_ff, rsp_end_in;

   ifsf_pkg::slot_type          pick;
   ifsf_pkg::slot_type          remaining;
   ifsf_pkg::slot_type          new_slots;
   ifsf_pkg::cfg_type           cfg;
   logic                        emit;
   logic                        accept;
   logic                        csr_write;
   logic                        opening;
   logic [ifsf_pkg::BYTE_W-1:0] check_new;
   logic [ifsf_pkg::BYTE_W-1:0] control_new;
   logic                        data_stuff;
   logic                        check_stuff;
   logic [ifsf_pkg::BYTE_W-1:0] mux_byte;
   logic                        mux_end;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Register writes.
   always_comb begin
      flag_in     = flag_ff;
      escape_in   = escape_ff;
      address_in  = address_ff;
      seq_mask_in = seq_mask_ff;
      if (csr_write) begin
         unique case (csr_index)
            ifsf_pkg::CSR_FLAG:     flag_in     = csr_data;
            ifsf_pkg::CSR_ESCAPE:   escape_in   = csr_data;
            ifsf_pkg::CSR_ADDRESS:  address_in  = csr_data;
            ifsf_pkg::CSR_SEQ_MASK: seq_mask_in = csr_data;
            default: begin
               flag_in = flag_ff;
            end
         endcase
      end
   end

   assign cfg.flag    = flag_ff;
   assign cfg.escape  = escape_ff;
   assign cfg.address = address_ff;

   // Slot walker: the lowest outstanding slot leaves next.
   assign pick      = pending_ff & (~pending_ff + ifsf_pkg::SLOT_COUNT'(1));
   assign remaining = pending_ff & ~pick;
   assign emit      = (pending_ff != '0) && (!rsp_valid_ff || rsp_ready);

   // Take a new beat once the held one has no slots beyond the one leaving now.
   assign req_ready = (remaining == '0) && ((pending_ff == '0) || emit);
   assign accept    = req_valid & req_ready;

   // Decode the incoming beat into its slots.
   assign opening     = !inside_ff;
   assign check_new   = (opening ? '0 : check_ff) ^ req_data_byte;
   assign control_new = req_sequence_bit ? seq_mask_ff : '0;
   assign data_stuff  = (req_data_byte == flag_ff) || (req_data_byte == escape_ff);
   assign check_stuff = (check_new == flag_ff) || (check_new == escape_ff);

   always_comb begin
      new_slots = '0;
      new_slots[ifsf_pkg::SLOT_OPEN_FLAG] = opening;
      new_slots[ifsf_pkg::SLOT_ADDRESS]   = opening;
      new_slots[ifsf_pkg::SLOT_CONTROL]   = opening;
      new_slots[ifsf_pkg::SLOT_BCC1]      = opening;
      new_slots[ifsf_pkg::SLOT_DATA_ESC]  = data_stuff;
      new_slots[ifsf_pkg::SLOT_DATA]      = 1'b1;
      new_slots[ifsf_pkg::SLOT_BCC2_ESC]  = req_last_byte & check_stuff;
      new_slots[ifsf_pkg::SLOT_BCC2]      = req_last_byte;
      new_slots[ifsf_pkg::SLOT_CLOSE]     = req_last_byte;
   end

   always_comb begin
      item_in    = item_ff;
      pending_in = pending_ff;
      check_in   = check_ff;
      inside_in  = inside_ff;
      if (accept) begin
         item_in.data        = req_data_byte;
         item_in.data_stuff  = data_stuff;
         item_in.check       = check_new;
         item_in.check_stuff = check_stuff;
         // Hold the previous C byte mid-frame; the sequence bit is only sampled on open.
         item_in.control     = opening ? control_new : item_ff.control;
         pending_in          = new_slots;
         check_in            = check_new;
         inside_in           = !req_last_byte;
      end else if (emit) begin
         pending_in = remaining;
      end
   end

   ifsf_slot_mux u_slot_mux (
      .slot       (pick),
      .item       (item_ff),
      .cfg        (cfg),
      .frame_byte (mux_byte),
      .frame_end  (mux_end)
   );

   // Output register: load on emit, drop valid once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = mux_byte;
         rsp_last_in  = (remaining == '0);
         rsp_end_in   = mux_end;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= ifsf_pkg::FLAG_RESET;
         escape_ff    <= ifsf_pkg::ESCAPE_RESET;
         address_ff   <= ifsf_pkg::ADDRESS_RESET;
         seq_mask_ff  <= ifsf_pkg::SEQ_MASK_RESET;
         check_ff     <= '0;
         inside_ff    <= 1'b0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flag_ff      <= flag_in;
         escape_ff    <= escape_in;
         address_ff   <= address_in;
         seq_mask_ff  <= seq_mask_in;
         check_ff     <= check_in;
         inside_ff    <= inside_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_frame_end  = rsp_end_ff;

   // A closing flag always ends the run of its input beat.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_end_ff |-> rsp_last_ff)
      else $error("closing flag without run_last");

   // Never take a new beat while the held one still has slots to send.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> (remaining == '0))
      else $error("input beat accepted over pending slots");

   // A beat taken outside a frame starts with the opening flag.
   a_open_header: assert property (@(posedge clock) disable iff (reset)
      accept && !inside_ff |=> pending_ff[ifsf_pkg::SLOT_OPEN_FLAG])
      else $error("frame opened without header");

   // Every accepted beat carries its data slot.
   a_data_slot: assert property (@(posedge clock) disable iff (reset)
      accept |=> pending_ff[ifsf_pkg::SLOT_DATA])
      else $error("data slot missing");

endmodule
`default_nettype wire
